// ===== src/windowed_min_jump_cost_dp_defines.svh =====
// ----------------------------------------------------------------------------
// windowed_min_jump_cost_dp_defines.svh
// Assertion macros shared by the windowed minimum jump cost block.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_MIN_JUMP_COST_DP_DEFINES_SVH
`define WINDOWED_MIN_JUMP_COST_DP_DEFINES_SVH

// same-cycle implication, checked on clk with the reset held off
`define WMJC_CHECK(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wmjc check failed");

// next-cycle implication
`define WMJC_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wmjc next-cycle check failed");

`endif

// ===== src/wmjc_pkg.sv =====
// ----------------------------------------------------------------------------
// wmjc_pkg
// Types, constants and helpers for the windowed minimum jump cost block.
// ----------------------------------------------------------------------------
package wmjc_pkg;

    // ring depth (largest jump the hardware can look back)
    localparam int MAX_JUMP = 16;

    localparam int HEIGHT_W = 16;
    localparam int COST_W   = 32;
    localparam int CFG_W    = 5;
    localparam int ENTRY_W  = COST_W + HEIGHT_W;
    localparam int BEST_W   = COST_W + 1;

    localparam int PTR_W = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
    localparam int CNT_W = $clog2(MAX_JUMP + 1);
    localparam int WIN_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // configuration bus
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MAX_JUMP = 1'b0;
    localparam logic [CFG_W-1:0] MAX_JUMP_RST = CFG_W'(2);

    localparam logic [COST_W-1:0] COST_TOP = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    // controls for the shared add/compare unit
    typedef struct packed {
        logic load_zero;  // first item of a run: best = 0
        logic load_max;   // start of a scan: best = all ones
        logic step;       // fold one ring entry into best
    } cmp_ctl_t;

    // ring slot before p, wrapping at the ring depth
    function automatic logic [PTR_W-1:0] prev_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == '0)
            r = PTR_W'(MAX_JUMP - 1);
        else
            r = p - PTR_W'(1);
        return r;
    endfunction

    // ring slot after p, wrapping at the ring depth
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(MAX_JUMP - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

endpackage

// ===== src/windowed_min_jump_cost_dp.sv =====
// ----------------------------------------------------------------------------
// windowed_min_jump_cost_dp
// Least total jump cost per item of a run of heights, with jumps of up to
// max_jump items, each costing the absolute height difference.
// ----------------------------------------------------------------------------
//
//  channel   dir  transaction
//  -------   ---  -----------------------------------------------
//  s_*       in   tdata[15:0] height, tlast ends the run
//  m_*       out  tdata[31:0] cost, tuser saturated, tlast final
//  apb       cfg  0x0: max_jump[4:0]
//
//  After an item is accepted, the sequencer scans the last w ring entries,
//  w = min(max_jump, items seen in the run), then writes the result back;
//  a run's first item skips the scan. The next item is accepted only after
//  that write-back. The ring RAM gives one earlier entry per cycle to
//  the shared add/compare unit. s_tready is high only while the sequencer
//  is idle; a result held by m_tready stalls the write-back step only.
//  Reset clears the sequencer, ring pointer and item count; ring contents
//  need no clearing, since only entries of the current run are read.
//
module windowed_min_jump_cost_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    // input stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] height
    input  logic                         s_tlast,
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [31:0] cost
    output logic                         m_tuser,   // [0] saturated
    output logic                         m_tlast,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wmjc_pkg::PADDR_W-1:0] paddr,
    input  logic [wmjc_pkg::PDATA_W-1:0] pwdata,
    output logic [wmjc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

`include "windowed_min_jump_cost_dp_defines.svh"

    localparam int PTR_W = wmjc_pkg::PTR_W;
    localparam int CNT_W = wmjc_pkg::CNT_W;
    localparam int WIN_W = wmjc_pkg::WIN_W;

    wmjc_pkg::state_t state_reg, state_next;

    logic [wmjc_pkg::CFG_W-1:0]    max_jump_reg;
    logic [PTR_W-1:0]              ptr_reg, ptr_next;
    logic [CNT_W-1:0]              items_seen_reg, items_seen_next;
    logic [PTR_W-1:0]              rd_addr_reg;
    logic [PTR_W-1:0]              rd_addr;
    logic [WIN_W-1:0]              dist_reg, dist_next;
    logic [WIN_W-1:0]              win_reg, win_next;
    logic [wmjc_pkg::HEIGHT_W-1:0] height_reg;
    logic                          last_reg;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [wmjc_pkg::COST_W-1:0]   m_tdata_reg;
    logic                          m_tuser_reg;
    logic                          m_tlast_reg;

    logic                          accept;
    logic                          out_free;
    logic                          wb;
    logic [WIN_W-1:0]              jump_lim;
    logic [WIN_W-1:0]              mj_ext;
    logic [WIN_W-1:0]              seen_ext;

    wmjc_pkg::cmp_ctl_t            ctl;
    logic [wmjc_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [wmjc_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [wmjc_pkg::COST_W-1:0]   cost;
    logic                          saturated;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_jump_reg <= wmjc_pkg::MAX_JUMP_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == wmjc_pkg::REG_MAX_JUMP))
        begin
            max_jump_reg <= pwdata[wmjc_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == wmjc_pkg::REG_MAX_JUMP)
            prdata = wmjc_pkg::PDATA_W'(max_jump_reg);
    end

    // jump window: max_jump clamped to 1..MAX_JUMP, then to items seen
    always_comb
    begin
        mj_ext   = WIN_W'(max_jump_reg);
        seen_ext = WIN_W'(items_seen_reg);
        if (mj_ext == '0)
            jump_lim = WIN_W'(1);
        else if (mj_ext > WIN_W'(wmjc_pkg::MAX_JUMP))
            jump_lim = WIN_W'(wmjc_pkg::MAX_JUMP);
        else
            jump_lim = mj_ext;
        if (jump_lim > seen_ext)
            jump_lim = seen_ext;
    end

    assign s_tready = (state_reg == wmjc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ring read address: one slot further back each cycle outside idle
    assign rd_addr = (state_reg == wmjc_pkg::ST_IDLE) ? wmjc_pkg::prev_slot(ptr_reg)
                                                      : wmjc_pkg::prev_slot(rd_addr_reg);

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wmjc_pkg::ST_IDLE;
            ptr_reg        <= '0;
            items_seen_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            items_seen_reg <= items_seen_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // sequencer next state and unit controls
    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        items_seen_next = items_seen_reg;
        dist_next       = dist_reg;
        win_next        = win_reg;
        ctl             = '0;
        wb              = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            wmjc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    dist_next = WIN_W'(1);
                    win_next  = jump_lim;
                    if (items_seen_reg == '0)
                    begin
                        ctl.load_zero = 1'b1;
                        state_next    = wmjc_pkg::ST_WRITE;
                    end
                    else
                    begin
                        ctl.load_max = 1'b1;
                        state_next   = wmjc_pkg::ST_SCAN;
                    end
                end
            end
            wmjc_pkg::ST_SCAN:
            begin
                ctl.step = 1'b1;
                if (dist_reg == win_reg)
                    state_next = wmjc_pkg::ST_WRITE;
                else
                    dist_next = dist_reg + WIN_W'(1);
            end
            wmjc_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    wb            = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = wmjc_pkg::ST_IDLE;
                    if (last_reg)
                    begin
                        ptr_next        = '0;
                        items_seen_next = '0;
                    end
                    else
                    begin
                        ptr_next = wmjc_pkg::next_slot(ptr_reg);
                        if (items_seen_reg < CNT_W'(wmjc_pkg::MAX_JUMP))
                            items_seen_next = items_seen_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = wmjc_pkg::ST_IDLE;
            end
        endcase
    end

    // item and scan payload registers
    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr;
        dist_reg    <= dist_next;
        win_reg     <= win_next;
        if (accept)
        begin
            height_reg <= s_tdata;
            last_reg   <= s_tlast;
        end
        if (wb)
        begin
            m_tdata_reg <= cost;
            m_tuser_reg <= saturated;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ring of {cost, height}
    assign ram_wdata = {cost, height_reg};

    wmjc_ram #(
        .WIDTH (wmjc_pkg::ENTRY_W),
        .DEPTH (wmjc_pkg::MAX_JUMP)
    ) u_ring (
        .clk   (clk),
        .we    (wb),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // shared add/compare unit
    wmjc_cmp u_cmp (
        .clk         (clk),
        .ctl         (ctl),
        .height      (height_reg),
        .prev_height (ram_rdata[wmjc_pkg::HEIGHT_W-1:0]),
        .prev_cost   (ram_rdata[wmjc_pkg::ENTRY_W-1:wmjc_pkg::HEIGHT_W]),
        .cost        (cost),
        .saturated   (saturated)
    );

    // checks
    `WMJC_CHECK(a_sat_flag, m_tvalid, m_tuser == (m_tdata == wmjc_pkg::COST_TOP))
    `WMJC_CHECK_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `WMJC_CHECK(a_items_bound, 1'b1, items_seen_reg <= CNT_W'(wmjc_pkg::MAX_JUMP))
    `WMJC_CHECK(a_scan_dist, state_reg == wmjc_pkg::ST_SCAN,
                (dist_reg != '0) && (dist_reg <= win_reg))

endmodule

// ===== src/wmjc_ram.sv =====
// ----------------------------------------------------------------------------
// wmjc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmjc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/wmjc_cmp.sv =====
// ----------------------------------------------------------------------------
// wmjc_cmp
// Shared add/compare unit: folds one earlier ring entry per cycle into the
// running minimum cost and clamps the result to the cost range.
// ----------------------------------------------------------------------------
module wmjc_cmp (
    input  logic                          clk,
    input  wmjc_pkg::cmp_ctl_t            ctl,
    input  logic [wmjc_pkg::HEIGHT_W-1:0] height,
    input  logic [wmjc_pkg::HEIGHT_W-1:0] prev_height,
    input  logic [wmjc_pkg::COST_W-1:0]   prev_cost,
    output logic [wmjc_pkg::COST_W-1:0]   cost,
    output logic                          saturated
);

    logic [wmjc_pkg::BEST_W-1:0]   best_reg;
    logic [wmjc_pkg::BEST_W-1:0]   best_next;
    logic [wmjc_pkg::HEIGHT_W-1:0] diff;
    logic [wmjc_pkg::BEST_W-1:0]   cand;

    // |h - ph| plus the stored cost, then keep the smaller
    always_comb
    begin
        if (height >= prev_height)
            diff = height - prev_height;
        else
            diff = prev_height - height;
        cand = {1'b0, prev_cost} + wmjc_pkg::BEST_W'(diff);

        best_next = best_reg;
        if (ctl.load_zero)
            best_next = '0;
        else if (ctl.load_max)
            best_next = '1;
        else if (ctl.step && (cand < best_reg))
            best_next = cand;
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    // clamp at the top of the cost range
    always_comb
    begin
        if (best_reg >= {1'b0, wmjc_pkg::COST_TOP})
        begin
            cost      = wmjc_pkg::COST_TOP;
            saturated = 1'b1;
        end
        else
        begin
            cost      = best_reg[wmjc_pkg::COST_W-1:0];
            saturated = 1'b0;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for windowed_min_jump_cost_dp. Heights are streamed in
// runs, and each result is checked against a cycle-free model of the forward
// jump-cost recurrence kept in this file. Stimulus has three parts. A short
// table of directed runs covers reset, extreme heights and the edge cases of
// the jump limit. Randomized phases follow, each under its own max_jump.
// A final single-step run of alternating extremes goes with no idling.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_JUMP = wmjc_pkg::MAX_JUMP;
    localparam int HEIGHT_W = wmjc_pkg::HEIGHT_W;
    localparam int COST_W   = wmjc_pkg::COST_W;
    localparam int CFG_W    = wmjc_pkg::CFG_W;
    localparam int PADDR_W  = wmjc_pkg::PADDR_W;
    localparam int PDATA_W  = wmjc_pkg::PDATA_W;
    localparam logic [COST_W-1:0] COST_TOP    = wmjc_pkg::COST_TOP;
    localparam logic [CFG_W-1:0]  MAX_JUMP_RST = wmjc_pkg::MAX_JUMP_RST;

    localparam logic [PADDR_W-1:0] ADDR_MAX_JUMP =
        PADDR_W'(4 * int'(wmjc_pkg::REG_MAX_JUMP));
    localparam int DRAIN_CYCLES = MAX_JUMP + 4;
    localparam int PHASE_ITEMS  = 90;
    localparam int FINAL_ITEMS  = 80;

    // one result transaction
    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              saturated;
        logic              final_res;
    } jump_result_t;

    // one row of the directed table
    typedef struct {
        logic                wr_cfg;
        logic [CFG_W-1:0]    cfg;
        logic [HEIGHT_W-1:0] height;
        logic                last;
        logic                known;
        logic [COST_W-1:0]   cost;
        logic                sat;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;   // [15:0] height
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;   // [31:0] cost
    logic                m_tuser;   // [0] saturated
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // model state: ring of the current run plus the jump limit register
    logic [HEIGHT_W-1:0] height_hist [MAX_JUMP];
    logic [COST_W-1:0]   cost_hist   [MAX_JUMP];
    int                  run_len;
    int                  slot_ptr;
    logic [CFG_W-1:0]    jump_limit;

    jump_result_t        pending_costs [$];
    int                  err_count;
    bit                  idle_on;
    int                  stall_left;

    windowed_min_jump_cost_dp u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    function automatic void report_mismatch(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // forward recurrence: cheapest of the last w entries plus the height step
    function automatic jump_result_t predict_jump_cost(input logic [HEIGHT_W-1:0] h,
                                                       input logic is_last);
        jump_result_t        r;
        logic [COST_W:0]     best;
        logic [COST_W:0]     cand;
        logic [HEIGHT_W-1:0] ph;
        logic [HEIGHT_W-1:0] diff;
        int                  w;
        int                  idx;
        best = '0;
        if (run_len != 0)
        begin
            w = (jump_limit == '0) ? 1 : int'(jump_limit);
            if (w > MAX_JUMP)
                w = MAX_JUMP;
            if (w > run_len)
                w = run_len;
            best = '1;
            for (int d = 1; d <= w; d++)
            begin
                idx  = (slot_ptr + MAX_JUMP - d) % MAX_JUMP;
                ph   = height_hist[idx];
                diff = (h >= ph) ? h - ph : ph - h;
                cand = {1'b0, cost_hist[idx]} + (COST_W+1)'(diff);
                if (cand < best)
                    best = cand;
            end
        end
        // clamp at the top of the cost range
        if (best >= {1'b0, COST_TOP})
        begin
            r.cost      = COST_TOP;
            r.saturated = 1'b1;
        end
        else
        begin
            r.cost      = best[COST_W-1:0];
            r.saturated = 1'b0;
        end
        r.final_res = is_last;
        height_hist[slot_ptr] = h;
        cost_hist[slot_ptr]   = r.cost;
        slot_ptr = (slot_ptr + 1) % MAX_JUMP;
        if (run_len < MAX_JUMP)
            run_len++;
        if (is_last)
        begin
            run_len  = 0;
            slot_ptr = 0;
        end
        return r;
    endfunction

    // one height transaction, with an optional idle gap ahead of it
    task automatic send_height(input logic [HEIGHT_W-1:0] h, input logic is_last,
                               input logic known, input logic [COST_W-1:0] kcost,
                               input logic ksat);
        int           gap;
        jump_result_t r;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 3)) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = predict_jump_cost(h, is_last);
        if (known)
        begin
            r.cost      = kcost;
            r.saturated = ksat;
        end
        pending_costs.insert(pending_costs.size(), r);
    endtask

    // stop sending and let every pending result come out
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_costs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one APB transaction; the read data is taken in the access phase
    task automatic apb_xfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_MAX_JUMP;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write max_jump and read it back
    task automatic set_jump_limit(input logic [CFG_W-1:0] v);
        logic [PDATA_W-1:0] rd;
        apb_xfer(1'b1, PDATA_W'(v), rd);
        jump_limit = v;
        apb_xfer(1'b0, '0, rd);
        if (rd !== PDATA_W'(v))
            report_mismatch($sformatf("max_jump read exp %0d got %0d", v, rd));
    endtask

    // receiver back-pressure in short bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        jump_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_costs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result cost %0d", m_tdata));
            end
            else
            begin
                want = pending_costs.pop_front();
                if (m_tdata !== want.cost)
                    report_mismatch($sformatf("cost exp %0d got %0d", want.cost, m_tdata));
                if (m_tuser !== want.saturated)
                    report_mismatch($sformatf("saturated exp %0b got %0b",
                                              want.saturated, m_tuser));
                if (m_tlast !== want.final_res)
                    report_mismatch($sformatf("final exp %0b got %0b",
                                              want.final_res, m_tlast));
            end
        end
    end

    // watchdog
    initial
    begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        dir_row_t dir_rows [22];
        int cfg_plan [9];
        logic [PDATA_W-1:0] rd;
        int run_left;
        int style;
        int base;
        logic [HEIGHT_W-1:0] h;

        dir_rows = '{
            // reset limit of 2: extremes and a two-item skip
            '{0, 0,     0, 0, 1,     0, 0},
            '{0, 0, 65535, 0, 1, 65535, 0},
            '{0, 0,     0, 0, 1,     0, 0},
            '{0, 0, 65535, 1, 1, 65535, 0},
            // run of one item
            '{0, 0, 12345, 1, 1,     0, 0},
            // zero limit behaves as one
            '{1, 0,   100, 0, 1,     0, 0},
            '{0, 0,    50, 0, 1,    50, 0},
            '{0, 0,   100, 1, 1,   100, 0},
            // limit above ring depth
            '{1, 31,   10, 0, 1,     0, 0},
            '{0, 0, 65535, 0, 0,     0, 0},
            '{0, 0,     0, 0, 0,     0, 0},
            '{0, 0, 40000, 0, 0,     0, 0},
            '{0, 0,     5, 0, 0,     0, 0},
            '{0, 0, 65535, 1, 0,     0, 0},
            '{1, 17,    7, 0, 1,     0, 0},
            '{0, 0,     9, 0, 0,     0, 0},
            '{0, 0, 65535, 0, 0,     0, 0},
            '{0, 0,     1, 1, 0,     0, 0},
            // limit at ring depth, short history
            '{1, 16, 65535, 0, 1,    0, 0},
            '{0, 0,     0, 0, 1, 65535, 0},
            '{0, 0, 32768, 0, 0,     0, 0},
            '{0, 0, 65535, 1, 0,     0, 0}
        };
        cfg_plan = '{1, 16, 0, 31, 17, 2, 8, 3, 15};

        // quiet inputs and reset
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b1;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        err_count  = 0;
        stall_left = 0;
        idle_on    = 1'b1;
        run_len    = 0;
        slot_ptr   = 0;
        jump_limit = MAX_JUMP_RST;
        for (int i = 0; i < MAX_JUMP; i++)
        begin
            height_hist[i] = '0;
            cost_hist[i]   = '0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // register holds its reset value
        apb_xfer(1'b0, '0, rd);
        if (rd !== PDATA_W'(MAX_JUMP_RST))
            report_mismatch($sformatf("max_jump reset exp %0d got %0d", MAX_JUMP_RST, rd));

        // directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].wr_cfg)
            begin
                drain_results();
                set_jump_limit(dir_rows[i].cfg);
            end
            send_height(dir_rows[i].height, dir_rows[i].last, dir_rows[i].known,
                        dir_rows[i].cost, dir_rows[i].sat);
        end

        // random phases; a run may span a limit change
        run_left = 0;
        style    = 0;
        base     = 0;
        foreach (cfg_plan[p])
        begin
            drain_results();
            set_jump_limit((p < 6) ? CFG_W'(cfg_plan[p]) : CFG_W'($urandom_range(0, 31)));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (run_left == 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       run_left = $urandom_range(1, 3);
                        1, 2:    run_left = $urandom_range(17, 40);
                        default: run_left = $urandom_range(1, 20);
                    endcase
                    style = $urandom_range(0, 3);
                    base  = $urandom_range(0, 65535 - 255);
                end
                case (style)
                    0:       h = HEIGHT_W'($urandom);
                    1:       h = HEIGHT_W'(base + $urandom_range(0, 255));
                    2:       h = $urandom_range(0, 1) ? '1 : '0;
                    default: h = HEIGHT_W'($urandom_range(0, 15));
                endcase
                run_left--;
                send_height(h, run_left == 0, 1'b0, '0, 1'b0);
                // now and then let the pipe run dry mid-stream
                if ($urandom_range(0, 59) == 0)
                    drain_results();
            end
        end

        // final single-step run of alternating extremes, no idling
        drain_results();
        idle_on = 1'b0;
        set_jump_limit(CFG_W'(1));
        for (int n = 0; n < FINAL_ITEMS; n++)
            send_height((n % 2) ? '1 : '0, n == FINAL_ITEMS - 1, 1'b0, '0, 1'b0);

        drain_results();
        if (err_count == 0 && pending_costs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
